/* hdl/blam_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blam_pkg
// Shared widths, register indexes, types and the restoring divide step for
// the blocked lattice address map.
// ----------------------------------------------------------------------------
package blam_pkg;

	localparam int DIMS      = 4;
	localparam int LANES     = 2 * DIMS;
	localparam int REG_W     = 7;
	localparam int COORD_W   = 6;
	localparam int ADDR_W    = 24;
	localparam int CFG_IDX_W = 3;
	localparam int S1_STEPS  = 3;

	localparam int DEFAULT_MAX_EXTENT = 64;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_Z      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_W      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SUBBLOCK_EDGE = 3'd4;

	localparam logic [REG_W-1:0] EXTENT_RESET = 7'd16;
	localparam logic [REG_W-1:0] EDGE_RESET   = 7'd4;

	typedef logic [REG_W-1:0]  reg_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		reg_t [DIMS-1:0] extent;
		reg_t            sub_edge;
	} cfg_t;

	typedef struct packed {
		logic q;
		reg_t rem;
	} div_step_t;

	// One restoring divide step: shift in a dividend bit, subtract if it fits
	function automatic div_step_t div_step(reg_t rem, logic din, reg_t d);
		logic [REG_W:0] t;
		div_step_t      r;
		t = {rem, din};
		if (t >= {1'b0, d}) begin
			r.q   = 1'b1;
			r.rem = REG_W'(t - {1'b0, d});
		end else begin
			r.q   = 1'b0;
			r.rem = REG_W'(t);
		end
		return r;
	endfunction

endpackage

/* hdl/blam_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blam_cfg_regs
// Register file for the four extents and the subblock edge, written through
// a plain enable/index/data port. Unknown indexes are dropped.
// ----------------------------------------------------------------------------
module blam_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [blam_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [blam_pkg::REG_W-1:0]      cfg_data,
	output blam_pkg::cfg_t                  cfg
);

	blam_pkg::cfg_t cfg_q;

	// Write the addressed register, ignore indexes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < blam_pkg::DIMS; i++) begin
				cfg_q.extent[i] <= blam_pkg::EXTENT_RESET;
			end
			cfg_q.sub_edge <= blam_pkg::EDGE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				blam_pkg::CFG_EXTENT_X:      cfg_q.extent[0] <= cfg_data;
				blam_pkg::CFG_EXTENT_Y:      cfg_q.extent[1] <= cfg_data;
				blam_pkg::CFG_EXTENT_Z:      cfg_q.extent[2] <= cfg_data;
				blam_pkg::CFG_EXTENT_W:      cfg_q.extent[3] <= cfg_data;
				blam_pkg::CFG_SUBBLOCK_EDGE: cfg_q.sub_edge  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/blocked_lattice_address_map_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blocked_lattice_address_map_top
// Maps a 4D lattice site to its natural and subblock-tiled addresses.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on in_valid/in_ready carrying coord_x..coord_w (x fastest).
//   Results leave on out_valid/out_ready as tiled_address, natural_address
//   and map_error. Extents and subblock edge are written on the cfg port
//   while no item is in flight; an item may follow the write at once.
//   Throughput: one item per cycle unless the receiver stalls. The six
//   register stages are two halves of a restoring divider (coordinates
//   and extents by the edge, run in eight lanes) and four multiply stages:
//   three for the mixed-radix chains and a final one for subblock index
//   times edge^4 plus offset.
//   A bad coordinate, a bad extent, a zero edge or an extent the edge does
//   not divide raises map_error with both addresses at zero.
//   Reset empties the pipeline and restores extents of 16 and edge 4.
//   When the receiver stalls, the output stage holds its item; upstream
//   stages keep filling any empty slots, and in_ready drops only once every
//   stage holds an item.
// ----------------------------------------------------------------------------
module blocked_lattice_address_map_top #(
	parameter int MAX_EXTENT = blam_pkg::DEFAULT_MAX_EXTENT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [blam_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [blam_pkg::REG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [blam_pkg::COORD_W-1:0]      coord_x,
	input  logic [blam_pkg::COORD_W-1:0]      coord_y,
	input  logic [blam_pkg::COORD_W-1:0]      coord_z,
	input  logic [blam_pkg::COORD_W-1:0]      coord_w,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [blam_pkg::ADDR_W-1:0]       tiled_address,
	output logic [blam_pkg::ADDR_W-1:0]       natural_address,
	output logic                              map_error
);

	localparam int DIMS  = blam_pkg::DIMS;
	localparam int LANES = blam_pkg::LANES;
	localparam int REG_W = blam_pkg::REG_W;
	localparam int S1N   = blam_pkg::S1_STEPS;
	localparam logic [REG_W+1:0] MaxExt = (REG_W + 2)'(MAX_EXTENT);

	blam_pkg::cfg_t cfg;

	blam_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Stage load enables: a stage loads when empty or when the next one loads
	logic ld1, ld2, ld3, ld4, ld5, ld6;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	assign ld6 = !v_s6 || out_ready;
	assign ld5 = !v_s5 || ld6;
	assign ld4 = !v_s4 || ld5;
	assign ld3 = !v_s3 || ld4;
	assign ld2 = !v_s2 || ld3;
	assign ld1 = !v_s1 || ld2;
	assign in_ready = ld1;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= in_valid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
			if (ld4) v_s4 <= v_s3;
			if (ld5) v_s5 <= v_s4;
			if (ld6) v_s6 <= v_s5;
		end
	end

	// ---------------- Entry: range checks and upper divide steps ----------
	blam_pkg::reg_t [LANES-1:0] dvd_in;
	blam_pkg::reg_t [LANES-1:0] rem_a;
	blam_pkg::reg_t [LANES-1:0] quo_a;
	blam_pkg::div_step_t        st_a;
	logic                       err_in;

	always_comb begin
		dvd_in[0] = {1'b0, coord_x};
		dvd_in[1] = {1'b0, coord_y};
		dvd_in[2] = {1'b0, coord_z};
		dvd_in[3] = {1'b0, coord_w};
		for (int i = 0; i < DIMS; i++) begin
			dvd_in[DIMS+i] = cfg.extent[i];
		end
		err_in = (cfg.sub_edge == '0);
		for (int i = 0; i < DIMS; i++) begin
			if (cfg.extent[i] == '0 || {2'b00, cfg.extent[i]} > MaxExt) err_in = 1'b1;
			if (dvd_in[i] >= cfg.extent[i]) err_in = 1'b1;
		end
	end

	always_comb begin
		st_a = '0;
		for (int k = 0; k < LANES; k++) begin
			rem_a[k] = '0;
			quo_a[k] = '0;
			for (int j = REG_W - 1; j >= REG_W - S1N; j--) begin
				st_a        = blam_pkg::div_step(rem_a[k], dvd_in[k][j], cfg.sub_edge);
				rem_a[k]    = st_a.rem;
				quo_a[k][j] = st_a.q;
			end
		end
	end

	blam_pkg::reg_t [LANES-1:0] dvd_s1, rem_s1, quo_s1;
	blam_pkg::reg_t             edge_s1;
	logic                       err_s1;

	always_ff @(posedge clk) begin
		if (ld1) begin
			dvd_s1  <= dvd_in;
			rem_s1  <= rem_a;
			quo_s1  <= quo_a;
			edge_s1 <= cfg.sub_edge;
			err_s1  <= err_in;
		end
	end

	// ---------------- Stage 2: lower divide steps, divisibility ------------
	blam_pkg::reg_t [LANES-1:0] rem_b, quo_b;
	blam_pkg::div_step_t        st_b;
	logic                       err_b;

	always_comb begin
		st_b = '0;
		for (int k = 0; k < LANES; k++) begin
			rem_b[k] = rem_s1[k];
			quo_b[k] = quo_s1[k];
			for (int j = REG_W - S1N - 1; j >= 0; j--) begin
				st_b        = blam_pkg::div_step(rem_b[k], dvd_s1[k][j], edge_s1);
				rem_b[k]    = st_b.rem;
				quo_b[k][j] = st_b.q;
			end
		end
		err_b = err_s1;
		for (int i = 0; i < DIMS; i++) begin
			if (rem_b[DIMS+i] != '0) err_b = 1'b1;
		end
	end

	blam_pkg::reg_t [LANES-1:0] dvd_s2, rem_s2, quo_s2;
	blam_pkg::reg_t             edge_s2;
	logic                       err_s2;

	always_ff @(posedge clk) begin
		if (ld2) begin
			dvd_s2  <= dvd_s1;
			rem_s2  <= rem_b;
			quo_s2  <= quo_b;
			edge_s2 <= edge_s1;
			err_s2  <= err_b;
		end
	end

	// ---------------- Stage 3: w and z digits of each chain, edge squared --
	blam_pkg::addr_t nat_s3, blk_s3, off_s3, vol_s3;
	blam_pkg::reg_t  x_s3, y_s3, ex_s3, ey_s3, qx_s3, qy_s3, nx_s3, ny_s3;
	blam_pkg::reg_t  rx_s3, ry_s3, edge_s3;
	logic            err_s3;

	always_ff @(posedge clk) begin
		if (ld3) begin
			nat_s3  <= blam_pkg::addr_t'(dvd_s2[3]) * blam_pkg::addr_t'(dvd_s2[DIMS+2])
				+ blam_pkg::addr_t'(dvd_s2[2]);
			blk_s3  <= blam_pkg::addr_t'(quo_s2[3]) * blam_pkg::addr_t'(quo_s2[DIMS+2])
				+ blam_pkg::addr_t'(quo_s2[2]);
			off_s3  <= blam_pkg::addr_t'(rem_s2[3]) * blam_pkg::addr_t'(edge_s2)
				+ blam_pkg::addr_t'(rem_s2[2]);
			vol_s3  <= blam_pkg::addr_t'(edge_s2) * blam_pkg::addr_t'(edge_s2);
			x_s3    <= dvd_s2[0];
			y_s3    <= dvd_s2[1];
			ex_s3   <= dvd_s2[DIMS];
			ey_s3   <= dvd_s2[DIMS+1];
			qx_s3   <= quo_s2[0];
			qy_s3   <= quo_s2[1];
			nx_s3   <= quo_s2[DIMS];
			ny_s3   <= quo_s2[DIMS+1];
			rx_s3   <= rem_s2[0];
			ry_s3   <= rem_s2[1];
			edge_s3 <= edge_s2;
			err_s3  <= err_s2;
		end
	end

	// ---------------- Stage 4: y digits, edge to the fourth ----------------
	blam_pkg::addr_t nat_s4, blk_s4, off_s4, vol_s4;
	blam_pkg::reg_t  x_s4, ex_s4, qx_s4, nx_s4, rx_s4, edge_s4;
	logic            err_s4;

	always_ff @(posedge clk) begin
		if (ld4) begin
			nat_s4  <= nat_s3 * blam_pkg::addr_t'(ey_s3) + blam_pkg::addr_t'(y_s3);
			blk_s4  <= blk_s3 * blam_pkg::addr_t'(ny_s3) + blam_pkg::addr_t'(qy_s3);
			off_s4  <= off_s3 * blam_pkg::addr_t'(edge_s3) + blam_pkg::addr_t'(ry_s3);
			vol_s4  <= vol_s3 * vol_s3;
			x_s4    <= x_s3;
			ex_s4   <= ex_s3;
			qx_s4   <= qx_s3;
			nx_s4   <= nx_s3;
			rx_s4   <= rx_s3;
			edge_s4 <= edge_s3;
			err_s4  <= err_s3;
		end
	end

	// ---------------- Stage 5: x digits close the chains -------------------
	blam_pkg::addr_t nat_s5, blk_s5, off_s5, vol_s5;
	logic            err_s5;

	always_ff @(posedge clk) begin
		if (ld5) begin
			nat_s5 <= nat_s4 * blam_pkg::addr_t'(ex_s4) + blam_pkg::addr_t'(x_s4);
			blk_s5 <= blk_s4 * blam_pkg::addr_t'(nx_s4) + blam_pkg::addr_t'(qx_s4);
			off_s5 <= off_s4 * blam_pkg::addr_t'(edge_s4) + blam_pkg::addr_t'(rx_s4);
			vol_s5 <= vol_s4;
			err_s5 <= err_s4;
		end
	end

	// ---------------- Stage 6: tiled address, zero both on error -----------
	blam_pkg::addr_t tiled_s6, nat_s6;
	logic            err_s6;

	always_ff @(posedge clk) begin
		if (ld6) begin
			tiled_s6 <= err_s5 ? '0 : blk_s5 * vol_s5 + off_s5;
			nat_s6   <= err_s5 ? '0 : nat_s5;
			err_s6   <= err_s5;
		end
	end

	assign out_valid       = v_s6;
	assign tiled_address   = tiled_s6;
	assign natural_address = nat_s6;
	assign map_error       = err_s6;

	// ---------------- Assertions ----------------
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && map_error |-> tiled_address == '0 && natural_address == '0)
		else $error("error item carries a nonzero address");

	a_ready_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while the receiver takes items");

	a_zero_edge: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && edge_s2 == '0 |-> err_s2)
		else $error("zero edge not flagged");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && edge_s2 != '0 |-> rem_s2[0] < edge_s2 && rem_s2[DIMS] < edge_s2)
		else $error("divider remainder not below edge");

endmodule
